### rtl/core/dahdsr_pkg.sv
package dahdsr_pkg;

	localparam int SAMPLES_PER_CHUNK = 8;
	localparam logic [31:0] FULL_LEVEL = 32'h4000_0000;
	localparam logic [15:0] SUSTAIN_COUNT = 16'hFFFF;
	localparam int GAIN_SHIFT = 14;
	localparam int STEP_SHIFT = 17;
	localparam int DIV_BITS = 33;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DELAY, ST_ATTACK, ST_HOLD, ST_DECAY, ST_SUSTAIN, ST_RELEASE, ST_FORCED
	} stage_t;

	typedef enum logic [1:0] {
		K_NOTE_ON, K_NOTE_OFF, K_CHUNK, K_UNUSED
	} kind_t;

	typedef enum logic [2:0] {
		REG_DELAY, REG_ATTACK, REG_HOLD, REG_DECAY, REG_SUSTAIN, REG_RELEASE, REG_RETRIG,
		REG_NONE
	} reg_idx_t;

	typedef enum logic [2:0] {
		C_IDLE, C_EVENT, C_ADV, C_WAIT, C_MUL, C_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic signed [15:0] sample_0;
		logic signed [15:0] sample_1;
		logic signed [15:0] sample_2;
		logic signed [15:0] sample_3;
		logic signed [15:0] sample_4;
		logic signed [15:0] sample_5;
		logic signed [15:0] sample_6;
		logic signed [15:0] sample_7;
	} in_t;

	typedef struct packed {
		logic signed [15:0] out_0;
		logic signed [15:0] out_1;
		logic signed [15:0] out_2;
		logic signed [15:0] out_3;
		logic signed [15:0] out_4;
		logic signed [15:0] out_5;
		logic signed [15:0] out_6;
		logic signed [15:0] out_7;
		logic [2:0] stage;
	} out_t;

	typedef struct packed {
		logic load_in;
		logic note_on;
		logic note_off;
		logic advance;
		logic mul_start;
		logic mul_step;
		logic mul_end;
		logic [2:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic stage_idle;
		logic chunks_zero;
		logic div_busy;
	} sts_t;

endpackage

### rtl/core/dahdsr_envelope_gain_top.sv
// Envelope gain block: delay, attack, hold, decay, sustain and release stages,
// with a forced fade on retrigger, applied to chunks of eight 16-bit samples.
// A request on the input channel is a note-on, a note-off or a sample chunk.
// Only a chunk makes a result request on the output channel: eight scaled
// samples and the stage in which the chunk was processed.
// One request is handled at a time; in_stall stays high until it is finished
// and, for a chunk, until its result has been taken.
// A note event that starts a slope waits for the divider before it finishes.
// A chunk first steps through each stage that has run out, and each stage
// change that starts a slope waits for the divider; the 33-step divider
// finds each slope and the one multiplier scales one sample a cycle.
// The result is held while out_stall is high and nothing else moves.
// Configuration writes are registered and are read by any later event or stage change, also within a request.
// Reset returns the envelope to idle with zero level and the registers to
// their default lengths and sustain level.
module dahdsr_envelope_gain_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input dahdsr_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output dahdsr_pkg::out_t out_data,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [30:0] cfg_data
);
	import dahdsr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dahdsr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts(sts),
		.cmd(cmd)
	);

	dahdsr_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.cmd(cmd),
		.sts(sts),
		.out_data(out_data)
	);

endmodule

### rtl/core/dahdsr_div.sv
module dahdsr_div (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic signed [32:0] num,
	input logic [15:0] den,
	output logic busy,
	output logic [31:0] quo
);
	import dahdsr_pkg::*;

	logic [5:0] cnt_q;
	logic busy_q;
	logic neg_q;
	logic [15:0] den_q;
	logic [15:0] rem_q;
	logic [32:0] quo_q;
	logic [32:0] mag;
	logic [16:0] shifted;
	logic fits;
	logic [32:0] signed_quo;

	assign mag = num[32] ? 33'(-num) : num;
	assign shifted = {rem_q, quo_q[32]};
	assign fits = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q <= 6'(DIV_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Restoring division on the magnitude, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= num[32];
			den_q <= den;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(shifted - {1'b0, den_q}) : shifted[15:0];
			quo_q <= {quo_q[31:0], fits};
		end
	end

	assign signed_quo = neg_q ? 33'(-quo_q) : quo_q;
	assign quo = signed_quo[31:0];
	assign busy = busy_q;

endmodule

### rtl/core/dahdsr_dp.sv
module dahdsr_dp (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [30:0] cfg_data,
	input dahdsr_pkg::in_t in_data,
	input dahdsr_pkg::cmd_t cmd,
	output dahdsr_pkg::sts_t sts,
	output dahdsr_pkg::out_t out_data
);
	import dahdsr_pkg::*;

	logic [15:0] delay_q, attack_q, hold_q, decay_q, release_q, retrig_q;
	logic [30:0] sustain_q;

	in_t item_q;
	stage_t stage_q, stage_n;
	logic [31:0] level_q, level_n;
	logic [31:0] step_q, step_n;
	logic [15:0] chunks_q, chunks_n;
	logic [31:0] g_q;
	logic [2:0] ostage_q;
	logic signed [15:0] outs_q [SAMPLES_PER_CHUNK];

	logic div_go;
	logic signed [32:0] div_num;
	logic [15:0] div_den;
	logic div_busy;
	logic div_busy_d_q;
	logic [31:0] div_quo;

	logic signed [15:0] samp;
	logic signed [47:0] prod;
	logic [31:0] d_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= 16'd0;
			attack_q <= 16'd58;
			hold_q <= 16'd14;
			decay_q <= 16'd193;
			sustain_q <= 31'd536870912;
			release_q <= 16'd1654;
			retrig_q <= 16'd28;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DELAY: delay_q <= cfg_data[15:0];
				REG_ATTACK: attack_q <= cfg_data[15:0];
				REG_HOLD: hold_q <= cfg_data[15:0];
				REG_DECAY: decay_q <= cfg_data[15:0];
				REG_SUSTAIN: sustain_q <= cfg_data;
				REG_RELEASE: release_q <= cfg_data[15:0];
				REG_RETRIG: retrig_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic do_clean, do_attack, do_decay, do_release, do_forced;
		do_clean = 1'b0;
		do_attack = 1'b0;
		do_decay = 1'b0;
		do_release = 1'b0;
		do_forced = 1'b0;
		stage_n = stage_q;
		chunks_n = chunks_q;
		level_n = level_q;
		step_n = step_q;
		div_go = 1'b0;
		div_num = '0;
		div_den = '0;

		if (cmd.note_on) begin
			if (stage_q == ST_IDLE || stage_q == ST_DELAY || retrig_q == 16'd0) begin
				do_clean = 1'b1;
			end else if (stage_q != ST_FORCED) begin
				do_forced = 1'b1;
			end
		end
		if (cmd.note_off) begin
			if (stage_q != ST_RELEASE && stage_q != ST_IDLE && stage_q != ST_FORCED) begin
				do_release = 1'b1;
			end
		end
		if (cmd.advance) begin
			unique case (stage_q)
				ST_DELAY: do_attack = 1'b1;
				ST_FORCED: do_clean = 1'b1;
				ST_ATTACK: begin
					if (hold_q != 16'd0) begin
						stage_n = ST_HOLD;
						chunks_n = hold_q;
						level_n = FULL_LEVEL;
						step_n = '0;
					end else begin
						do_decay = 1'b1;
					end
				end
				ST_HOLD: do_decay = 1'b1;
				ST_DECAY: begin
					stage_n = ST_SUSTAIN;
					chunks_n = SUSTAIN_COUNT;
					level_n = {1'b0, sustain_q};
					step_n = '0;
				end
				ST_SUSTAIN: chunks_n = SUSTAIN_COUNT;
				ST_RELEASE: stage_n = ST_IDLE;
				default: ;
			endcase
		end
		if (do_clean) begin
			if (delay_q != 16'd0) begin
				stage_n = ST_DELAY;
				chunks_n = delay_q;
				level_n = '0;
				step_n = '0;
			end else begin
				do_attack = 1'b1;
			end
		end
		if (do_attack) begin
			stage_n = ST_ATTACK;
			chunks_n = attack_q;
			if (attack_q == 16'd0) begin
				level_n = FULL_LEVEL;
				step_n = '0;
			end else begin
				level_n = '0;
				div_go = 1'b1;
				div_num = {1'b0, FULL_LEVEL};
				div_den = attack_q;
			end
		end
		if (do_decay) begin
			stage_n = ST_DECAY;
			chunks_n = decay_q;
			if (decay_q == 16'd0) begin
				level_n = {1'b0, sustain_q};
				step_n = '0;
			end else begin
				level_n = FULL_LEVEL;
				div_go = 1'b1;
				div_num = $signed({2'b00, sustain_q}) - $signed({1'b0, FULL_LEVEL});
				div_den = decay_q;
			end
		end
		if (do_release) begin
			stage_n = ST_RELEASE;
			chunks_n = release_q;
			if (release_q == 16'd0) begin
				level_n = '0;
				step_n = '0;
			end else begin
				div_go = 1'b1;
				div_num = 33'(-$signed({level_q[31], level_q}));
				div_den = release_q;
			end
		end
		if (do_forced) begin
			stage_n = ST_FORCED;
			chunks_n = retrig_q;
			div_go = 1'b1;
			div_num = 33'(-$signed({level_q[31], level_q}));
			div_den = retrig_q;
		end
		if (cmd.mul_end && stage_q != ST_IDLE) begin
			level_n = level_q + step_q;
			chunks_n = chunks_q - 16'd1;
		end
	end

	dahdsr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.num(div_num),
		.den(div_den),
		.busy(div_busy),
		.quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_IDLE;
			level_q <= '0;
			step_q <= '0;
			chunks_q <= '0;
			div_busy_d_q <= 1'b0;
		end else begin
			stage_q <= stage_n;
			level_q <= level_n;
			chunks_q <= chunks_n;
			div_busy_d_q <= div_busy;
			// The slope is loaded from the quotient once the delayed busy flag shows that the divider has finished.
			if (div_busy_d_q && !div_busy) begin
				step_q <= div_quo;
			end else begin
				step_q <= step_n;
			end
		end
	end

	always_comb begin
		case (cmd.idx)
			3'd0: samp = item_q.sample_0;
			3'd1: samp = item_q.sample_1;
			3'd2: samp = item_q.sample_2;
			3'd3: samp = item_q.sample_3;
			3'd4: samp = item_q.sample_4;
			3'd5: samp = item_q.sample_5;
			3'd6: samp = item_q.sample_6;
			default: samp = item_q.sample_7;
		endcase
	end

	assign d_step = 32'($signed(step_q) >>> STEP_SHIFT);
	assign prod = $signed(g_q + d_step) * samp;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			item_q <= in_data;
		end
		if (cmd.mul_start) begin
			g_q <= 32'($signed(level_q) >>> GAIN_SHIFT);
			ostage_q <= 3'(stage_q);
		end
		if (cmd.mul_step) begin
			g_q <= g_q + d_step;
			outs_q[cmd.idx] <= (ostage_q == 3'(ST_IDLE)) ? 16'sd0 : prod[31:16];
		end
	end

	assign sts.kind = item_q.kind;
	assign sts.stage_idle = (stage_q == ST_IDLE);
	assign sts.chunks_zero = (chunks_q == 16'd0);
	assign sts.div_busy = div_busy;

	assign out_data.out_0 = outs_q[0];
	assign out_data.out_1 = outs_q[1];
	assign out_data.out_2 = outs_q[2];
	assign out_data.out_3 = outs_q[3];
	assign out_data.out_4 = outs_q[4];
	assign out_data.out_5 = outs_q[5];
	assign out_data.out_6 = outs_q[6];
	assign out_data.out_7 = outs_q[7];
	assign out_data.stage = ostage_q;

endmodule

### rtl/core/dahdsr_ctrl.sv
module dahdsr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input dahdsr_pkg::sts_t sts,
	output dahdsr_pkg::cmd_t cmd
);
	import dahdsr_pkg::*;

	ctrl_state_t state_q, state_n;
	logic [2:0] cnt_q;
	logic ret_adv_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			C_IDLE: if (in_valid) state_n = C_EVENT;
			C_EVENT: begin
				unique case (kind_t'(sts.kind))
					K_NOTE_ON, K_NOTE_OFF: state_n = C_WAIT;
					K_CHUNK: state_n = C_ADV;
					default: state_n = C_IDLE;
				endcase
			end
			C_ADV: begin
				if (!sts.stage_idle && sts.chunks_zero) begin
					state_n = C_WAIT;
				end else begin
					state_n = C_MUL;
				end
			end
			C_WAIT: begin
				if (!sts.div_busy) begin
					state_n = ret_adv_q ? C_ADV : C_IDLE;
				end
			end
			C_MUL: if (cnt_q == 3'(SAMPLES_PER_CHUNK - 1)) state_n = C_OUT;
			C_OUT: if (!out_stall) state_n = C_IDLE;
			default: state_n = C_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.idx = cnt_q;
		in_stall = (state_q != C_IDLE);
		out_valid = (state_q == C_OUT);
		unique case (state_q)
			C_IDLE: cmd.load_in = in_valid;
			C_EVENT: begin
				cmd.note_on = (sts.kind == K_NOTE_ON);
				cmd.note_off = (sts.kind == K_NOTE_OFF);
			end
			C_ADV: begin
				cmd.advance = !sts.stage_idle && sts.chunks_zero;
				cmd.mul_start = sts.stage_idle || !sts.chunks_zero;
			end
			C_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.mul_end = (cnt_q == 3'(SAMPLES_PER_CHUNK - 1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q <= '0;
			ret_adv_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == C_MUL) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == C_ADV) begin
				ret_adv_q <= 1'b1;
			end else if (state_q == C_EVENT) begin
				ret_adv_q <= 1'b0;
			end
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	a_no_div_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_MUL) |-> !sts.div_busy)
		else $error("samples scaled while the slope is still being divided");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("result repeated after delivery");

endmodule

### test/dahdsr_envelope_gain_top_test.sv
`timescale 1ns / 100ps

module dahdsr_envelope_gain_top_test;
	import dahdsr_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [30:0] cfg_data;

	dahdsr_envelope_gain_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Envelope state and register copies kept by the predictor.
	logic [15:0] len_delay, len_attack, len_hold, len_decay, len_release, len_retrig;
	logic [31:0] sustain_gain;
	stage_t env_stage;
	logic [31:0] env_level;
	logic [31:0] env_step;
	logic [15:0] env_left;

	out_t pending_chunks[$];
	int failures;
	int hold_off_cycles;
	bit stall_pattern_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [31:0] slope_of(logic [31:0] from_lvl, logic [31:0] to_lvl,
			logic [15:0] chunks);
		longint span;
		span = longint'($signed(to_lvl)) - longint'($signed(from_lvl));
		return 32'(span / longint'({16'd0, chunks}));
	endfunction

	task automatic start_slope(logic [31:0] from_lvl, logic [31:0] to_lvl, logic [15:0] chunks);
		if (chunks == 16'd0) begin
			env_level = to_lvl;
			env_step = '0;
		end else begin
			env_level = from_lvl;
			env_step = slope_of(from_lvl, to_lvl, chunks);
		end
	endtask

	task automatic enter_attack();
		env_stage = ST_ATTACK;
		env_left = len_attack;
		start_slope('0, FULL_LEVEL, env_left);
	endtask

	task automatic restart_envelope();
		env_left = len_delay;
		if (env_left != 16'd0) begin
			env_stage = ST_DELAY;
			env_level = '0;
			env_step = '0;
		end else begin
			enter_attack();
		end
	endtask

	task automatic enter_decay();
		env_stage = ST_DECAY;
		env_left = len_decay;
		start_slope(FULL_LEVEL, sustain_gain, env_left);
	endtask

	task automatic reset_envelope_model();
		len_delay = 16'd0;
		len_attack = 16'd58;
		len_hold = 16'd14;
		len_decay = 16'd193;
		sustain_gain = 32'd536870912;
		len_release = 16'd1654;
		len_retrig = 16'd28;
		env_stage = ST_IDLE;
		env_level = '0;
		env_step = '0;
		env_left = '0;
	endtask

	// Works out the effect of one accepted request; a chunk queues its result.
	task automatic predict_request(in_t req);
		logic [15:0] smp[8];
		logic signed [31:0] g, d;
		longint prod;
		out_t res;
		smp = '{req.sample_0, req.sample_1, req.sample_2, req.sample_3,
			req.sample_4, req.sample_5, req.sample_6, req.sample_7};
		case (kind_t'(req.kind))
			K_NOTE_ON: begin
				if (env_stage == ST_IDLE || env_stage == ST_DELAY || len_retrig == 16'd0) begin
					restart_envelope();
				end else if (env_stage != ST_FORCED) begin
					env_stage = ST_FORCED;
					env_left = len_retrig;
					env_step = slope_of(env_level, '0, env_left);
				end
			end
			K_NOTE_OFF: begin
				if (env_stage != ST_RELEASE && env_stage != ST_IDLE && env_stage != ST_FORCED) begin
					env_stage = ST_RELEASE;
					env_left = len_release;
					start_slope(env_level, '0, env_left);
				end
			end
			K_CHUNK: begin
				while (env_left == 16'd0 && env_stage != ST_IDLE) begin
					case (env_stage)
						ST_DELAY: enter_attack();
						ST_FORCED: restart_envelope();
						ST_ATTACK: begin
							env_left = len_hold;
							if (env_left != 16'd0) begin
								env_stage = ST_HOLD;
								env_level = FULL_LEVEL;
								env_step = '0;
							end else begin
								enter_decay();
							end
						end
						ST_HOLD: enter_decay();
						ST_DECAY: begin
							env_stage = ST_SUSTAIN;
							env_left = SUSTAIN_COUNT;
							env_level = sustain_gain;
							env_step = '0;
						end
						ST_SUSTAIN: env_left = SUSTAIN_COUNT;
						default: env_stage = ST_IDLE;
					endcase
				end
				res = '0;
				res.stage = ST_IDLE;
				if (env_stage != ST_IDLE) begin
					g = $signed(env_level) >>> GAIN_SHIFT;
					d = $signed(env_step) >>> STEP_SHIFT;
					for (int i = 0; i < 8; i++) begin
						g = g + d;
						prod = longint'(g) * longint'($signed(smp[i]));
						smp[i] = prod[31:16];
					end
					res = {smp[0], smp[1], smp[2], smp[3], smp[4], smp[5], smp[6], smp[7],
						3'(env_stage)};
					env_level = env_level + env_step;
					env_left = env_left - 16'd1;
				end
				pending_chunks.push_back(res);
			end
			default: ;
		endcase
	endtask

	// Predicts at the accepting edge so the expectation exists before any result.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			predict_request(in_data);
	end

	always @(posedge clk) begin
		out_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chunks.size() == 0) begin
				$error("unexpected result: %h", out_data);
				failures++;
			end else begin
				exp_res = pending_chunks.pop_front();
				if (out_data.out_0 !== exp_res.out_0) begin
					$error("out_0 expected %h got %h", exp_res.out_0, out_data.out_0); failures++;
				end
				if (out_data.out_1 !== exp_res.out_1) begin
					$error("out_1 expected %h got %h", exp_res.out_1, out_data.out_1); failures++;
				end
				if (out_data.out_2 !== exp_res.out_2) begin
					$error("out_2 expected %h got %h", exp_res.out_2, out_data.out_2); failures++;
				end
				if (out_data.out_3 !== exp_res.out_3) begin
					$error("out_3 expected %h got %h", exp_res.out_3, out_data.out_3); failures++;
				end
				if (out_data.out_4 !== exp_res.out_4) begin
					$error("out_4 expected %h got %h", exp_res.out_4, out_data.out_4); failures++;
				end
				if (out_data.out_5 !== exp_res.out_5) begin
					$error("out_5 expected %h got %h", exp_res.out_5, out_data.out_5); failures++;
				end
				if (out_data.out_6 !== exp_res.out_6) begin
					$error("out_6 expected %h got %h", exp_res.out_6, out_data.out_6); failures++;
				end
				if (out_data.out_7 !== exp_res.out_7) begin
					$error("out_7 expected %h got %h", exp_res.out_7, out_data.out_7); failures++;
				end
				if (out_data.stage !== exp_res.stage) begin
					$error("stage expected %0d got %0d", exp_res.stage, out_data.stage); failures++;
				end
			end
		end
	end

	// Receiver: a random stall pattern, a long hold-off on demand, or none at all.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_stall <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else if (stall_pattern_on) begin
			out_stall <= ($urandom_range(0, 3) == 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Drives at the falling edge, so the next request may follow in the same step.
	task automatic send_request(kind_t k, logic [15:0] smp[8]);
		in_data = {2'(k), smp[0], smp[1], smp[2], smp[3], smp[4], smp[5], smp[6], smp[7]};
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_random_request(kind_t k);
		logic [15:0] smp[8];
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 5))
				0: smp[i] = 16'h8000;
				1: smp[i] = 16'h7FFF;
				2: smp[i] = 16'hFFFF;
				default: smp[i] = 16'($urandom);
			endcase
		end
		send_request(k, smp);
	endtask

	task automatic write_register(reg_idx_t idx, logic [30:0] value);
		cfg_index = idx;
		cfg_data = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx != REG_NONE) begin
			case (idx)
				REG_DELAY: len_delay = value[15:0];
				REG_ATTACK: len_attack = value[15:0];
				REG_HOLD: len_hold = value[15:0];
				REG_DECAY: len_decay = value[15:0];
				REG_SUSTAIN: sustain_gain = {1'b0, value};
				REG_RELEASE: len_release = value[15:0];
				default: len_retrig = value[15:0];
			endcase
		end
	endtask

	// Waits for every queued result, then for a note event still in progress.
	task automatic drain();
		int guard;
		guard = 0;
		while (pending_chunks.size() != 0 && guard < 200_000) begin
			@(negedge clk);
			guard++;
		end
		if (guard >= 200_000) begin
			$display("CHECKS FAILED");
			$finish;
		end
		repeat (60) @(negedge clk);
	endtask

	task automatic write_all(logic [15:0] dl, logic [15:0] at, logic [15:0] hd,
			logic [15:0] dc, logic [30:0] su, logic [15:0] rl, logic [15:0] rt);
		drain();
		write_register(REG_DELAY, 31'(dl));
		write_register(REG_ATTACK, 31'(at));
		write_register(REG_HOLD, 31'(hd));
		write_register(REG_DECAY, 31'(dc));
		write_register(REG_SUSTAIN, su);
		write_register(REG_RELEASE, 31'(rl));
		write_register(REG_RETRIG, 31'(rt));
	endtask

	task automatic test_directed();
		logic [15:0] ext[8];
		ext = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h7FFF};
		send_request(K_CHUNK, ext);
		send_request(K_NOTE_OFF, ext);
		send_request(K_UNUSED, ext);
		write_all(16'd2, 16'd0, 16'd1, 16'd0, 31'h40000000, 16'd0, 16'd0);
		write_register(REG_NONE, 31'h7FFFFFFF);
		send_request(K_NOTE_ON, ext);
		repeat (4) send_request(K_CHUNK, ext);
		send_request(K_NOTE_ON, ext);
		send_request(K_CHUNK, ext);
		send_request(K_NOTE_OFF, ext);
		send_request(K_CHUNK, ext);
		send_request(K_CHUNK, ext);
		write_all(16'd0, 16'd2, 16'd0, 16'd2, 31'h7FFFFFFF, 16'd3, 16'd2);
		send_request(K_NOTE_ON, ext);
		repeat (3) send_request(K_CHUNK, ext);
		send_request(K_NOTE_ON, ext);
		send_request(K_NOTE_ON, ext);
		repeat (4) send_request(K_CHUNK, ext);
		send_request(K_NOTE_OFF, ext);
		repeat (4) send_request(K_CHUNK, ext);
	endtask

	// Note sequences with random content; mostly chunks so stages run their course.
	task automatic run_random(int count);
		int sent, burst, pick;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < count; b++) begin
				pick = $urandom_range(0, 99);
				if (pick < 6) send_random_request(K_NOTE_ON);
				else if (pick < 11) send_random_request(K_NOTE_OFF);
				else if (pick < 13) send_random_request(K_UNUSED);
				else send_random_request(K_CHUNK);
				sent++;
			end
			if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic test_short_settings();
		for (int p = 0; p < 6; p++) begin
			write_all(16'($urandom_range(0, 3)), 16'($urandom_range(0, 4)),
				16'($urandom_range(0, 3)), 16'($urandom_range(0, 4)),
				31'($urandom_range(0, 32'h40000000)), 16'($urandom_range(0, 5)),
				16'($urandom_range(0, 3)));
			stall_pattern_on = (p % 2 == 0);
			send_random_request(K_NOTE_ON);
			run_random(120);
		end
	endtask

	task automatic test_long_settings();
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFFFFFF, 16'hFFFF, 16'hFFFF);
		stall_pattern_on = 1'b1;
		run_random(60);
		write_all(16'd0, 16'hFFFF, 16'd0, 16'd1, 31'd0, 16'hFFFF, 16'd1);
		send_random_request(K_NOTE_ON);
		run_random(60);
	endtask

	task automatic test_backpressure();
		write_all(16'd0, 16'd3, 16'd2, 16'd3, 31'h20000000, 16'd4, 16'd2);
		send_random_request(K_NOTE_ON);
		hold_off_cycles = 400;
		run_random(40);
		drain();
		run_random(40);
	endtask

	initial begin
		failures = 0;
		hold_off_cycles = 0;
		stall_pattern_on = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_envelope_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_short_settings();
		test_long_settings();
		test_backpressure();
		drain();
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
